>>> design/swa_pkg.sv
// ----------------------------------------------------------------------------
// swa_pkg: shared constants, types and helpers
// Sizes of the window store and lag store, divider request/response bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package swa_pkg;

  localparam int NUM_WINDOWS   = 4;
  localparam int WINDOW_LENGTH = 16;

  localparam int LAG_W     = $clog2(WINDOW_LENGTH);
  localparam int B_W       = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
  localparam int WIN_DEPTH = NUM_WINDOWS * WINDOW_LENGTH;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int FILL_W    = LAG_W + 2;
  localparam int DUMP_LAGS = (WINDOW_LENGTH < 16) ? WINDOW_LENGTH : 16;

  localparam int DIV_N_W   = 7;

  typedef struct packed {
    logic                start;
    logic [63:0]         dividend;  // left-aligned
    logic [32:0]         divisor;
    logic [DIV_N_W-1:0]  nbits;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
    logic [32:0] remainder;
  } div_rsp_t;

  // Staggered start of window b
  function automatic logic signed [FILL_W-1:0] fill_init(input int b);
    fill_init = FILL_W'(-((b * WINDOW_LENGTH) / NUM_WINDOWS));
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      sat_add64 = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add64 = s;
    end
  endfunction

endpackage

`default_nettype wire

>>> design/swa_ram.sv
// ----------------------------------------------------------------------------
// swa_ram: generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module swa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

>>> design/swa_div.sv
// ----------------------------------------------------------------------------
// swa_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle over nbits steps.
// ----------------------------------------------------------------------------
`default_nettype none

module swa_div
  import swa_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic                busy_q;
  logic [DIV_N_W-1:0]  cnt_q;
  logic [63:0]         dvd_q;
  logic [63:0]         quo_q;
  logic [32:0]         rem_q;
  logic [32:0]         dsr_q;
  logic                done_q;

  logic [33:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem_q, dvd_q[63]};
  assign fits   = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.nbits;
        dvd_q  <= req_i.dividend;
        dsr_q  <= req_i.divisor;
        quo_q  <= '0;
        rem_q  <= '0;
      end else if (busy_q) begin
        dvd_q <= {dvd_q[62:0], 1'b0};
        quo_q <= {quo_q[62:0], fits};
        rem_q <= fits ? 33'(rem_sh - {1'b0, dsr_q}) : rem_sh[32:0];
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_N_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

>>> design/staggered_window_autocorrelator.sv
// ----------------------------------------------------------------------------
// staggered_window_autocorrelator: multi-origin lag autocorrelation
// Sequencer around one shared divider and one 32x32 multiplier.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream (s_axis): one request per sample, tdata = {sample, cycle}.
//    s_axis_tready is high only while the block is idle; one sample is
//    worked on at a time.
//  - Config channel (cfg_*): writes sample_interval, always ready; write only
//    while idle. Zero acts as one.
//  - Output stream (m_axis): on a sample that completes a window, one request
//    per lag 0..min(L,16)-1, tdata = {windows_done, lag_sum, lag_index},
//    tlast on the final lag. Each entry is held until taken; a stalled
//    receiver simply holds the dump, no data is lost.
// Work per sample (serial divider, one quotient bit per cycle):
//  - sample not on the interval: 32-step modulo by the interval, then ready.
//  - stored sample, no window done: store pass, 64-step mean divide, window
//    scan.
//  - each completed window adds L(L+1)/2 lag terms, each a 48-step divide by
//    the span; the dump passes each lag through read, load and output
//    states and waits in the output state while the receiver stalls.
// Reset: running sum, lag sums and window count clear, window fill counts
// restart at their staggered offsets, sample_interval returns to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module staggered_window_autocorrelator
  import swa_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // sample stream: [31:0] cycle_index, [63:32] sample_value
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [63:0]  s_axis_tdata,
  // result stream: [3:0] lag_index, [67:4] lag_sum, [99:68] windows_done
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [103:0]      m_axis_tdata,
  output logic              m_axis_tlast,
  // sample_interval write
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [15:0]  cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_MODW, S_WR, S_MEAN, S_MEANW, S_SCAN, S_RD,
    S_DEV, S_MUL, S_DIV, S_DIVW, S_ACC, S_DRD, S_DLD, S_DOUT
  } state_e;

  localparam logic signed [FILL_W-1:0] LEN_S = FILL_W'(WINDOW_LENGTH);

  state_e                    state_q;
  logic [15:0]               interval_q;
  logic [31:0]               cycle_q;
  logic signed [31:0]        x_q;
  logic signed [63:0]        rsum_q;
  logic signed [FILL_W-1:0]  fill_q [NUM_WINDOWS];
  logic [B_W-1:0]            b_q;
  logic [LAG_W-1:0]          t_q;
  logic [LAG_W-1:0]          i_q;
  logic signed [31:0]        mean_q;
  logic [31:0]               ma_q, mb_q;
  logic                      neg_q;
  logic [63:0]               prod_q;
  logic                      any_q;
  logic [31:0]               wins_q;
  logic [WINDOW_LENGTH-1:0]  lag_valid_q;
  logic                      m_valid_q;
  logic [3:0]                o_lag_q;
  logic [63:0]               o_sum_q;
  logic [31:0]               o_wins_q;
  logic                      o_last_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // window store
  logic                   win_we;
  logic [WIN_AW-1:0]      win_base, win_waddr, win_raddr_a, win_raddr_b;
  logic [31:0]            win_rd_a, win_rd_b;
  logic signed [FILL_W-1:0] cur_fill;

  // lag store
  logic [63:0]  lag_rd;
  logic signed [63:0] acc_cur, term, acc_new;
  logic [LAG_W:0] it_sum;

  // deviation
  logic signed [32:0] da, db;
  logic [15:0] ival;
  logic signed [63:0] rs_next;
  logic        rs_neg;
  logic [63:0] rs_mag;
  logic [LAG_W:0] span;
  logic last_b, last_i, last_t;

  assign cur_fill    = fill_q[b_q];
  assign win_base    = WIN_AW'(b_q) * WIN_AW'(WINDOW_LENGTH);
  assign win_we      = (state_q == S_WR) && !cur_fill[FILL_W-1] && (cur_fill < LEN_S);
  assign win_waddr   = win_base + WIN_AW'(cur_fill[LAG_W-1:0]);
  assign it_sum      = {1'b0, i_q} + {1'b0, t_q};
  assign win_raddr_a = win_base + WIN_AW'(i_q);
  assign win_raddr_b = win_base + WIN_AW'(it_sum);

  swa_ram #(.WIDTH(32), .DEPTH(WIN_DEPTH)) u_win_ram (
    .clk_i     (clk_i),
    .we_i      (win_we),
    .waddr_i   (win_waddr),
    .wdata_i   (x_q),
    .raddr_a_i (win_raddr_a),
    .rdata_a_o (win_rd_a),
    .raddr_b_i (win_raddr_b),
    .rdata_b_o (win_rd_b)
  );

  logic [63:0] lag_rd_unused;

  swa_ram #(.WIDTH(64), .DEPTH(WINDOW_LENGTH)) u_lag_ram (
    .clk_i     (clk_i),
    .we_i      (state_q == S_ACC),
    .waddr_i   (t_q),
    .wdata_i   (acc_new),
    .raddr_a_i (t_q),
    .rdata_a_o (lag_rd),
    .raddr_b_i (t_q),
    .rdata_b_o (lag_rd_unused)
  );

  // never-written lag entries read as zero
  assign acc_cur = lag_valid_q[t_q] ? lag_rd : 64'sd0;
  assign term    = neg_q ? -$signed({16'd0, div_rsp.quotient[47:0]})
                         :  $signed({16'd0, div_rsp.quotient[47:0]});
  assign acc_new = sat_add64(acc_cur, term);

  assign da = {win_rd_a[31], win_rd_a} - {mean_q[31], mean_q};
  assign db = {win_rd_b[31], win_rd_b} - {mean_q[31], mean_q};

  assign ival    = (interval_q == 16'd0) ? 16'd1 : interval_q;
  assign rs_neg  = rsum_q[63];
  assign rs_mag  = rs_neg ? 64'(-rsum_q) : rsum_q;
  assign rs_next = sat_add64(rsum_q, 64'(signed'(s_axis_tdata[63:32])));
  assign span    = (LAG_W+1)'(WINDOW_LENGTH) - {1'b0, t_q};

  assign last_b = (b_q == B_W'(NUM_WINDOWS - 1));
  assign last_i = (it_sum == (LAG_W+1)'(WINDOW_LENGTH - 1));
  assign last_t = (t_q == LAG_W'(WINDOW_LENGTH - 1));

  // shared divider requests
  always_comb begin
    div_req = '0;
    unique case (state_q)
      S_MOD: begin
        div_req.start    = 1'b1;
        div_req.dividend = {cycle_q, 32'd0};
        div_req.divisor  = 33'(ival);
        div_req.nbits    = DIV_N_W'(32);
      end
      S_MEAN: begin
        div_req.start    = 1'b1;
        div_req.dividend = rs_mag;
        div_req.divisor  = 33'(cycle_q) + 33'd1;
        div_req.nbits    = DIV_N_W'(64);
      end
      S_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {prod_q[63:16], 16'd0};
        div_req.divisor  = 33'(span);
        div_req.nbits    = DIV_N_W'(48);
      end
      default: ;
    endcase
  end

  swa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      interval_q  <= 16'd1;
      rsum_q      <= '0;
      for (int b = 0; b < NUM_WINDOWS; b++) begin
        fill_q[b] <= fill_init(b);
      end
      b_q         <= '0;
      t_q         <= '0;
      i_q         <= '0;
      any_q       <= 1'b0;
      wins_q      <= '0;
      lag_valid_q <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        interval_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cycle_q <= s_axis_tdata[31:0];
            x_q     <= s_axis_tdata[63:32];
            rsum_q  <= rs_next;
            state_q <= S_MOD;
          end
        end
        S_MOD: state_q <= S_MODW;
        S_MODW: begin
          if (div_rsp.done) begin
            b_q     <= '0;
            state_q <= (div_rsp.remainder == '0) ? S_WR : S_IDLE;
          end
        end
        S_WR: begin
          if (cur_fill < LEN_S) begin
            fill_q[b_q] <= cur_fill + 1'b1;
          end
          if (last_b) begin
            state_q <= S_MEAN;
          end else begin
            b_q <= b_q + 1'b1;
          end
        end
        S_MEAN: state_q <= S_MEANW;
        S_MEANW: begin
          if (div_rsp.done) begin
            // truncate toward zero, clamp to 32 bits
            if (rs_neg) begin
              mean_q <= (div_rsp.quotient > 64'h8000_0000) ? 32'sh8000_0000
                                                           : 32'(-div_rsp.quotient);
            end else begin
              mean_q <= (div_rsp.quotient > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                           : div_rsp.quotient[31:0];
            end
            b_q     <= '0;
            any_q   <= 1'b0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cur_fill == LEN_S) begin
            t_q     <= '0;
            i_q     <= '0;
            state_q <= S_RD;
          end else if (last_b) begin
            t_q     <= '0;
            state_q <= any_q ? S_DRD : S_IDLE;
          end else begin
            b_q <= b_q + 1'b1;
          end
        end
        S_RD: state_q <= S_DEV;
        S_DEV: begin
          ma_q    <= da[32] ? 32'(-da) : da[31:0];
          mb_q    <= db[32] ? 32'(-db) : db[31:0];
          neg_q   <= da[32] ^ db[32];
          state_q <= S_MUL;
        end
        S_MUL: begin
          prod_q  <= ma_q * mb_q;
          state_q <= S_DIV;
        end
        S_DIV: state_q <= S_DIVW;
        S_DIVW: begin
          if (div_rsp.done) begin
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          lag_valid_q[t_q] <= 1'b1;
          if (!last_i) begin
            i_q     <= i_q + 1'b1;
            state_q <= S_RD;
          end else if (!last_t) begin
            t_q     <= t_q + 1'b1;
            i_q     <= '0;
            state_q <= S_RD;
          end else begin
            // window done: restart it and count it
            fill_q[b_q] <= '0;
            any_q       <= 1'b1;
            if (wins_q != 32'hFFFF_FFFF) begin
              wins_q <= wins_q + 32'd1;
            end
            if (last_b) begin
              t_q     <= '0;
              state_q <= S_DRD;
            end else begin
              b_q     <= b_q + 1'b1;
              state_q <= S_SCAN;
            end
          end
        end
        S_DRD: state_q <= S_DLD;
        S_DLD: begin
          o_lag_q   <= 4'(t_q);
          o_sum_q   <= acc_cur;
          o_wins_q  <= wins_q;
          o_last_q  <= (t_q == LAG_W'(DUMP_LAGS - 1));
          m_valid_q <= 1'b1;
          state_q   <= S_DOUT;
        end
        S_DOUT: begin
          if (m_axis_tready) begin
            m_valid_q <= 1'b0;
            if (o_last_q) begin
              state_q <= S_IDLE;
            end else begin
              t_q     <= t_q + 1'b1;
              state_q <= S_DRD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'd0, o_wins_q, o_sum_q, o_lag_q};
  assign m_axis_tlast  = o_last_q;

endmodule

`default_nettype wire

>>> design/swa_checker.sv
// ----------------------------------------------------------------------------
// swa_checker: port-level checks
// Dump framing and one-item-at-a-time behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module swa_checker
  import swa_pkg::*;
(
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_tvalid_i,
  input wire logic         s_tready_i,
  input wire logic         m_tvalid_i,
  input wire logic         m_tready_i,
  input wire logic [103:0] m_tdata_i,
  input wire logic         m_tlast_i
);

  // held result stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i)
    else $error("result dropped while stalled");

  // no new sample while a dump is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_tvalid_i && s_tready_i))
    else $error("input ready during dump");

  // one sample at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("ready right after accept");

  // tlast marks the final lag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tlast_i |-> m_tdata_i[3:0] == 4'(DUMP_LAGS - 1))
    else $error("tlast on wrong lag");

endmodule

bind staggered_window_autocorrelator swa_checker u_swa_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid),
  .s_tready_i (s_axis_tready),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata),
  .m_tlast_i  (m_axis_tlast)
);

`default_nettype wire
